// ===== design/sc2a_pkg.sv =====
// Shared types, constants and key maps for the scan code to ASCII decoder.
`default_nettype none

package sc2a_pkg;

  // Configuration port geometry
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_F1_OUTPUT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_F2_OUTPUT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_OUTPUT = 2'd2;

  // Field widths
  localparam int CODE_W = 8;
  localparam int CHAR_W = 7;

  // Map geometry; codes at or above MAP_ENTRIES read as zero
  localparam int MAP_SIZE    = 64;
  localparam int MAP_IDX_W   = 6;
  localparam int MAP_ENTRIES = 64;

  // Special scan codes
  localparam logic [CODE_W-1:0] SC_ESCAPE      = 8'd1;
  localparam logic [CODE_W-1:0] SC_TAB         = 8'd15;
  localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE = 8'd42;
  localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE = 8'd54;
  localparam logic [CODE_W-1:0] SC_CAPS_LOCK   = 8'd58;
  localparam logic [CODE_W-1:0] SC_F1          = 8'd59;
  localparam logic [CODE_W-1:0] SC_F2          = 8'd60;
  localparam logic [CODE_W-1:0] SC_BREAK_FIRST = 8'd129;
  localparam logic [CODE_W-1:0] SC_LSHIFT_BRK  = 8'd170;
  localparam logic [CODE_W-1:0] SC_RSHIFT_BRK  = 8'd182;

  // Marker characters
  localparam logic [CHAR_W-1:0] CH_SHIFT_PRESS = 7'd15;
  localparam logic [CHAR_W-1:0] CH_MODIFIER    = 7'd14;
  localparam logic [CHAR_W-1:0] CH_LOWER_A     = 7'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z     = 7'd122;
  localparam logic [CHAR_W-1:0] CH_CASE_DELTA  = 7'd32;

  // Plain key map, indexed by scan code
  localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_SIZE] = '{
    7'd0,   7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
    7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
    7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
    7'd111, 7'd112, 7'd91,  7'd93,  7'd13,  7'd0,   7'd97,  7'd115,
    7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
    7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
    7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd0,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
  };

  // Shifted key map, indexed by scan code
  localparam logic [CHAR_W-1:0] SHIFTED_MAP [MAP_SIZE] = '{
    7'd0,   7'd27,  7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
    7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,
    7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
    7'd111, 7'd112, 7'd91,  7'd93,  7'd13,  7'd0,   7'd97,  7'd115,
    7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd58,
    7'd34,  7'd126, 7'd0,   7'd124, 7'd122, 7'd120, 7'd99,  7'd118,
    7'd98,  7'd110, 7'd109, 7'd60,  7'd62,  7'd63,  7'd0,   7'd0,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
  };

  // Programmable character codes
  typedef struct packed {
    logic [CHAR_W-1:0] f1_output;
    logic [CHAR_W-1:0] f2_output;
    logic [CHAR_W-1:0] escape_output;
  } cfg_t;

  // Decode result for one scan code
  typedef struct packed {
    logic              emit;
    logic [CHAR_W-1:0] char_code;
  } dec_res_t;

endpackage

`default_nettype wire

// ===== design/sc2a_if.sv =====
// Valid/ready channel interfaces for scan codes in and characters out.
`default_nettype none

interface sc2a_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

interface sc2a_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== design/sc2a_cfg_regs.sv =====
// APB-style register file holding the programmable F1, F2 and Escape codes.
`default_nettype none

module sc2a_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sc2a_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [sc2a_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [sc2a_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output sc2a_pkg::cfg_t                        cfg_o
);
  import sc2a_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  cfg_t                 cfg_q;
  cfg_t                 cfg_d;

  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Update the addressed register; ignore indexes beyond the list
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_F1_OUTPUT:     cfg_d.f1_output     = pwdata[CHAR_W-1:0];
        REG_F2_OUTPUT:     cfg_d.f2_output     = pwdata[CHAR_W-1:0];
        REG_ESCAPE_OUTPUT: cfg_d.escape_output = pwdata[CHAR_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.f1_output     <= 7'd1;
      cfg_q.f2_output     <= 7'd2;
      cfg_q.escape_output <= 7'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_F1_OUTPUT:     prdata = APB_DATA_W'(cfg_q.f1_output);
      REG_F2_OUTPUT:     prdata = APB_DATA_W'(cfg_q.f2_output);
      REG_ESCAPE_OUTPUT: prdata = APB_DATA_W'(cfg_q.escape_output);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

`ifndef SYNTHESIS
  a_f1_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && (reg_idx == REG_F1_OUTPUT) |=> cfg_q.f1_output == $past(pwdata[CHAR_W-1:0]))
    else $error("F1 register write lost");
  a_no_write_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(cfg_q))
    else $error("register changed without a write");
  a_escape_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && (reg_idx == REG_ESCAPE_OUTPUT)
      |=> cfg_q.escape_output == $past(pwdata[CHAR_W-1:0]))
    else $error("Escape register write lost");
`endif

endmodule

`default_nettype wire

// ===== design/sc2a_in_stage.sv =====
// Input register that captures one scan code per transaction.
`default_nettype none

module sc2a_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sc2a_scan_if.sink                        scan_i,
  input  wire logic                        down_ready_i,
  output logic                             valid_o,
  output logic      [sc2a_pkg::CODE_W-1:0] code_o
);
  import sc2a_pkg::*;

  logic              valid_q;
  logic              valid_d;
  logic [CODE_W-1:0] code_q;
  logic              take;

  // Accept whenever the stage is empty or drains this cycle
  assign scan_i.ready = !valid_q || down_ready_i;
  assign take         = scan_i.valid && scan_i.ready;
  assign valid_d      = take || (valid_q && !down_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (take) begin
      code_q <= scan_i.scan_code;
    end
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;

`ifndef SYNTHESIS
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !down_ready_i |=> valid_q && $stable(code_q))
    else $error("held scan code lost while downstream stalled");
  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> valid_q && (code_q == $past(scan_i.scan_code)))
    else $error("accepted scan code not captured");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && down_ready_i && !scan_i.valid |=> !valid_q)
    else $error("stage stayed full after draining");
`endif

endmodule

`default_nettype wire

// ===== design/sc2a_decode.sv =====
// Shift and caps-lock flags plus the scan code to character lookup.
`default_nettype none

module sc2a_decode (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire logic [sc2a_pkg::CODE_W-1:0] code_i,
  input  wire sc2a_pkg::cfg_t              cfg_i,
  output sc2a_pkg::dec_res_t               res_o
);
  import sc2a_pkg::*;

  logic              shift_q;
  logic              shift_d;
  logic              caps_q;
  logic              caps_d;
  logic              is_letter;
  logic              in_map;
  logic [CHAR_W-1:0] plain_ch;
  logic [CHAR_W-1:0] shifted_ch;
  dec_res_t          res;

  assign is_letter = ((code_i >= 8'd16) && (code_i <= 8'd25)) ||
                     ((code_i >= 8'd30) && (code_i <= 8'd38)) ||
                     ((code_i >= 8'd44) && (code_i <= 8'd50));

  // Codes past either map bound read as zero
  assign in_map     = (code_i < 8'(MAP_ENTRIES)) && (code_i < 8'(MAP_SIZE));
  assign plain_ch   = in_map ? PLAIN_MAP[code_i[MAP_IDX_W-1:0]] : '0;
  assign shifted_ch = in_map ? SHIFTED_MAP[code_i[MAP_IDX_W-1:0]] : '0;

  // Classify the code and pick the character
  always_comb begin
    shift_d       = shift_q;
    caps_d        = caps_q;
    res.emit      = 1'b1;
    res.char_code = '0;
    if ((code_i == SC_LSHIFT_MAKE) || (code_i == SC_RSHIFT_MAKE)) begin
      shift_d       = 1'b1;
      res.char_code = CH_SHIFT_PRESS;
    end else if ((code_i == SC_LSHIFT_BRK) || (code_i == SC_RSHIFT_BRK)) begin
      shift_d       = 1'b0;
      res.char_code = CH_MODIFIER;
    end else if (code_i == SC_CAPS_LOCK) begin
      caps_d        = !caps_q;
      res.char_code = CH_MODIFIER;
    end else if ((code_i == SC_TAB) || (code_i >= SC_BREAK_FIRST)) begin
      res.emit = 1'b0;
    end else if (code_i == SC_F1) begin
      res.char_code = cfg_i.f1_output;
    end else if (code_i == SC_F2) begin
      res.char_code = cfg_i.f2_output;
    end else if (code_i == SC_ESCAPE) begin
      res.char_code = cfg_i.escape_output;
    end else if (is_letter) begin
      res.char_code = plain_ch;
      if ((shift_q != caps_q) && (plain_ch >= CH_LOWER_A) && (plain_ch <= CH_LOWER_Z)) begin
        res.char_code = plain_ch - CH_CASE_DELTA;
      end
    end else begin
      res.char_code = shift_q ? shifted_ch : plain_ch;
    end
  end

  // Advance flags only when the code moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else if (advance_i) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(shift_q) && $stable(caps_q))
    else $error("modifier flags changed without a code");
  a_shift_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && ((code_i == SC_LSHIFT_MAKE) || (code_i == SC_RSHIFT_MAKE)) |=> shift_q)
    else $error("shift press did not set the shift flag");
  a_caps_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (code_i == SC_CAPS_LOCK) |=> caps_q != $past(caps_q))
    else $error("caps lock did not toggle");
  a_caps_only_on_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (code_i != SC_CAPS_LOCK) |=> $stable(caps_q))
    else $error("caps flag moved on another key");
`endif

endmodule

`default_nettype wire

// ===== design/sc2a_out_stage.sv =====
// Result register that presents one character per transaction.
`default_nettype none

module sc2a_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               up_valid_i,
  input  wire sc2a_pkg::dec_res_t res_i,
  output logic                    up_ready_o,
  sc2a_char_if.source             char_o
);
  import sc2a_pkg::*;

  logic              valid_q;
  logic              valid_d;
  logic [CHAR_W-1:0] char_q;
  logic              load;

  // Take a new result when empty or when the held one leaves
  assign up_ready_o = !valid_q || char_o.ready;
  assign load       = up_valid_i && up_ready_o && res_i.emit;
  assign valid_d    = up_ready_o ? load : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= res_i.char_code;
    end
  end

  assign char_o.valid     = valid_q;
  assign char_o.char_code = char_q;

`ifndef SYNTHESIS
  a_silent_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_valid_i && up_ready_o && !res_i.emit |=> !valid_q)
    else $error("result shown for a code with no character");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q && (char_q == $past(res_i.char_code)))
    else $error("decoded character not registered");
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !char_o.ready |-> !up_ready_o)
    else $error("upstream advanced into a stalled result register");
`endif

endmodule

`default_nettype wire

// ===== design/scancode_to_ascii_decoder_top.sv =====
// Top level of the set-1 scan code to ASCII decoder.
//
// scan_i (sink) carries one raw scan code byte per transaction; char_o
// (source) carries one 7-bit character per transaction. Both use
// valid/ready and move a transaction at a clock edge with both high.
// The APB-style port writes the F1, F2 and Escape codes at byte
// addresses 0, 4 and 8; pready is tied high.
// A code goes from the input register through a single lookup into
// the result register. Throughput: one code per cycle while the
// receiver does not stall. Tab, and codes 129 and up other than
// the shift releases, produce no transaction on char_o.
// Reset (rst_ni low, asynchronous) empties both registers, clears the
// shift and caps-lock flags and loads the codes 1, 2 and 3.
// When the receiver stalls, the result holds, the input register fills
// behind it and scan_i.ready then drops until the result is taken.
`default_nettype none

module scancode_to_ascii_decoder_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  sc2a_scan_if.sink                            scan_i,
  sc2a_char_if.source                          char_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sc2a_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [sc2a_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [sc2a_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import sc2a_pkg::*;

  cfg_t              cfg;
  logic              s1_valid;
  logic [CODE_W-1:0] s1_code;
  logic              s2_ready;
  logic              advance;
  dec_res_t          res;

  sc2a_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sc2a_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_i       (scan_i),
    .down_ready_i (s2_ready),
    .valid_o      (s1_valid),
    .code_o       (s1_code)
  );

  // Code moves from the input register into the result stage
  assign advance = s1_valid && s2_ready;

  sc2a_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .code_i    (s1_code),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  sc2a_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s1_valid),
    .res_i      (res),
    .up_ready_o (s2_ready),
    .char_o     (char_o)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.emit |=> char_o.valid)
    else $error("emitting code produced no result");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> scan_i.ready)
    else $error("empty input register refused a code");
  a_tab_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (s1_code == SC_TAB) |=> !char_o.valid)
    else $error("tab produced a result");
`endif

endmodule

`default_nettype wire

// ===== sim/scancode_to_ascii_decoder_top_tb.sv =====
// Self-checking testbench for the scan code to ASCII decoder top level.
`timescale 1ns / 100ps

module scancode_to_ascii_decoder_top_tb;
  import sc2a_pkg::*;

  localparam int KEYMAP_SIZE  = 64;
  localparam int DRAIN_CYCLES = 4;
  localparam int CHARS_PER_PHASE = 240;

  // Unused register slot; writes there must leave the codes alone
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Keys and out-of-map codes used by the directed sequence
  localparam logic [CODE_W-1:0] KEY_DIGIT_1   = 8'd2;
  localparam logic [CODE_W-1:0] KEY_Q         = 8'd16;
  localparam logic [CODE_W-1:0] KEY_SEMICOLON = 8'd39;
  localparam logic [CODE_W-1:0] KEY_LAST_MAP  = 8'd63;
  localparam logic [CODE_W-1:0] KEY_PAST_MAP  = 8'd64;
  localparam logic [CODE_W-1:0] KEY_MID_GAP   = 8'd127;
  localparam logic [CODE_W-1:0] KEY_LAST_GAP  = 8'd128;
  localparam logic [CODE_W-1:0] KEY_TOP       = 8'd255;

  // Characters for unshifted keys, by scan code
  localparam logic [CHAR_W-1:0] PLAIN_KEYS [KEYMAP_SIZE] = '{
    0,   27,  49,  50,  51,  52,  53,  54,  55,  56,  57,  48,  45,  61,  8,   9,
    113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91,  93,  13,  0,   97,
    115, 100, 102, 103, 104, 106, 107, 108, 59,  39,  96,  0,   92,  122, 120,
    99,  118, 98,  110, 109, 44,  46,  47,  0,   0,   0,   32,
    0,   0,   0,   0,   0,   0
  };

  // Characters for keys pressed with shift held, by scan code
  localparam logic [CHAR_W-1:0] SHIFTED_KEYS [KEYMAP_SIZE] = '{
    0,   27,  33,  64,  35,  36,  37,  94,  38,  42,  40,  41,  95,  43,  8,   9,
    113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91,  93,  13,  0,   97,
    115, 100, 102, 103, 104, 106, 107, 108, 58,  34,  126, 0,   124, 122, 120,
    99,  118, 98,  110, 109, 60,  62,  63,  0,   0,   0,   32,
    0,   0,   0,   0,   0,   0
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sc2a_scan_if scan_bus ();
  sc2a_char_if char_bus ();

  // Decoder state as the testbench sees it
  logic              shift_down;
  logic              caps_on;
  logic [CHAR_W-1:0] f1_char;
  logic [CHAR_W-1:0] f2_char;
  logic [CHAR_W-1:0] esc_char;

  logic [CHAR_W-1:0] expected_chars [$];
  logic [CHAR_W-1:0] oldest_char;
  int                chars_predicted;
  int                fail_count;
  int                sender_idle_pct;
  int                receiver_stall_pct;

  scancode_to_ascii_decoder_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .scan_i  (scan_bus),
    .char_o  (char_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one scan code, advance shift and caps state; return 1 if a character comes out
  function automatic logic decode_scan_code(input logic [CODE_W-1:0] code,
                                            output logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] plain;
    ch = '0;
    if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
      shift_down = 1'b1;
      ch = CH_SHIFT_PRESS;
    end else if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK) begin
      shift_down = 1'b0;
      ch = CH_MODIFIER;
    end else if (code == SC_CAPS_LOCK) begin
      caps_on = !caps_on;
      ch = CH_MODIFIER;
    end else if (code == SC_TAB || code >= SC_BREAK_FIRST) begin
      return 1'b0;
    end else if (code == SC_F1) begin
      ch = f1_char;
    end else if (code == SC_F2) begin
      ch = f2_char;
    end else if (code == SC_ESCAPE) begin
      ch = esc_char;
    end else if (code < KEYMAP_SIZE) begin
      plain = PLAIN_KEYS[code[5:0]];
      // Letters follow shift xor caps; everything else follows shift alone
      if (plain >= CH_LOWER_A && plain <= CH_LOWER_Z) begin
        ch = (shift_down != caps_on) ? plain - CH_CASE_DELTA : plain;
      end else begin
        ch = shift_down ? SHIFTED_KEYS[code[5:0]] : plain;
      end
    end
    return 1'b1;
  endfunction

  // Present one scan code, hold it until taken, then record its character
  task automatic send_scan(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    while ($urandom_range(99) < sender_idle_pct) begin
      scan_bus.valid <= 1'b0;
      @(posedge clk);
    end
    scan_bus.valid     <= 1'b1;
    scan_bus.scan_code <= code;
    do @(posedge clk); while (!scan_bus.ready);
    if (decode_scan_code(code, ch)) begin
      expected_chars.push_back(ch);
      chars_predicted++;
    end
  endtask

  // Drop valid and wait until the decoder has nothing in flight
  task automatic settle();
    scan_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB write; psel stays high so writes can follow back to back
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [APB_DATA_W-1:0] value);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    case (idx)
      REG_F1_OUTPUT:     f1_char  = value[CHAR_W-1:0];
      REG_F2_OUTPUT:     f2_char  = value[CHAR_W-1:0];
      REG_ESCAPE_OUTPUT: esc_char = value[CHAR_W-1:0];
      default: ;
    endcase
  endtask

  // Load all three function key codes and poke the unused slot
  task automatic program_codes(input logic [APB_DATA_W-1:0] f1_val,
                               input logic [APB_DATA_W-1:0] f2_val,
                               input logic [APB_DATA_W-1:0] esc_val);
    write_reg(REG_F1_OUTPUT, f1_val);
    write_reg(REG_F2_OUTPUT, f2_val);
    write_reg(REG_ESCAPE_OUTPUT, esc_val);
    write_reg(REG_UNUSED, $urandom());
    psel   <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Reset codes, every special key, shift and caps combinations, code range edges
  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_scan('0);
    send_scan(SC_ESCAPE);
    send_scan(SC_F1);
    send_scan(SC_F2);
    send_scan(SC_TAB);
    send_scan(KEY_DIGIT_1);
    send_scan(KEY_Q);
    send_scan(SC_LSHIFT_MAKE);
    send_scan(KEY_DIGIT_1);
    send_scan(KEY_Q);
    // caps on while shift held: letters drop back to lower case
    send_scan(SC_CAPS_LOCK);
    send_scan(KEY_Q);
    send_scan(SC_LSHIFT_BRK);
    send_scan(KEY_Q);
    send_scan(KEY_SEMICOLON);
    send_scan(SC_RSHIFT_MAKE);
    send_scan(KEY_SEMICOLON);
    send_scan(SC_RSHIFT_BRK);
    send_scan(SC_CAPS_LOCK);
    send_scan(KEY_LAST_MAP);
    send_scan(KEY_PAST_MAP);
    send_scan(KEY_MID_GAP);
    send_scan(KEY_LAST_GAP);
    send_scan(SC_BREAK_FIRST);
    send_scan(KEY_TOP);
  endtask

  // Function key codes at both extremes, with junk above the code bits, and random
  task automatic test_registers();
    for (int setting = 0; setting < 3; setting++) begin
      settle();
      case (setting)
        0:       program_codes(32'hFFFF_FF80, 32'hFFFF_FF80, 32'hFFFF_FF80);
        1:       program_codes(32'h0000_007F, 32'h0000_007F, 32'h0000_007F);
        default: program_codes($urandom(), $urandom(), $urandom());
      endcase
      send_scan(SC_F1);
      send_scan(SC_F2);
      send_scan(SC_ESCAPE);
      send_scan(SC_RSHIFT_MAKE);
      send_scan(SC_F1);
      send_scan(SC_RSHIFT_BRK);
    end
  endtask

  // Mostly real key traffic with shift and caps churn, some gaps and break noise
  task automatic test_random();
    int                start_count;
    int                roll;
    logic [CODE_W-1:0] code;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      program_codes($urandom(), $urandom(), $urandom());
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
      endcase
      start_count = chars_predicted;
      while (chars_predicted - start_count < CHARS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 50) begin
          code = CODE_W'($urandom_range(KEYMAP_SIZE - 1));
        end else if (roll < 58) begin
          code = $urandom_range(1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
        end else if (roll < 66) begin
          code = $urandom_range(1) ? SC_LSHIFT_BRK : SC_RSHIFT_BRK;
        end else if (roll < 71) begin
          code = SC_CAPS_LOCK;
        end else if (roll < 79) begin
          case ($urandom_range(3))
            0:       code = SC_TAB;
            1:       code = SC_F1;
            2:       code = SC_F2;
            default: code = SC_ESCAPE;
          endcase
        end else if (roll < 87) begin
          code = CODE_W'($urandom_range(128, 64));
        end else begin
          code = CODE_W'($urandom_range(255, 129));
        end
        send_scan(code);
      end
    end
  endtask

  // Randomly stall the character receiver
  always @(posedge clk) begin
    char_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare each character transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && char_bus.valid && char_bus.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: char_code expected none, got %0d", $time, char_bus.char_code);
        fail_count++;
      end else begin
        oldest_char = expected_chars.pop_front();
        if (char_bus.char_code !== oldest_char) begin
          $display("%0t: char_code expected %0d, got %0d",
                   $time, oldest_char, char_bus.char_code);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    scan_bus.valid     = 1'b0;
    scan_bus.scan_code = '0;
    char_bus.ready     = 1'b0;
    shift_down         = 1'b0;
    caps_on            = 1'b0;
    f1_char            = 7'd1;
    f2_char            = 7'd2;
    esc_char           = 7'd3;
    chars_predicted    = 0;
    fail_count         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_registers();
    test_random();
    settle();

    if (fail_count == 0) begin
      $display("scancode_to_ascii_decoder_top: match");
    end else begin
      $display("scancode_to_ascii_decoder_top: mismatch");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("scancode_to_ascii_decoder_top: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sc2a_pkg.sv
design/sc2a_if.sv
design/sc2a_cfg_regs.sv
design/sc2a_in_stage.sv
design/sc2a_decode.sv
design/sc2a_out_stage.sv
design/scancode_to_ascii_decoder_top.sv
sim/scancode_to_ascii_decoder_top_tb.sv
